// ===== hw/rtl/rccm_pkg.sv =====
// ----------------------------------------------------------------------------
// rccm_pkg
// shared types, constants and register indexes of the rc capacitance meter
// ----------------------------------------------------------------------------
package rccm_pkg;

    localparam int MAX_RANGES_DEFAULT = 4;

    localparam int RES_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 32;
    localparam int NUM_W     = 42;
    localparam int THR_W     = 35;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 88;

    localparam logic [SAMPLE_W-1:0] CHARGE_LEVEL = 10'd648;
    localparam logic [TIME_W-1:0]   LONG_US      = 32'd3000000;
    localparam logic [TIME_W-1:0]   SHORT_US     = 32'd1000000;
    localparam logic [10:0]         MIN_NF       = 11'd1300;
    localparam logic [9:0]          NF_SCALE     = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_R_OHM_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_OHM_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_OHM_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_OHM_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIS_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_LEVEL  = 3'd7;

    typedef enum logic [1:0] {
        MODE_SAFE = 2'd0,
        MODE_DIS  = 2'd1,
        MODE_CHG  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic div_load;
        logic div_step;
        logic div_finish;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic div_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/rccm_div.sv =====
// ----------------------------------------------------------------------------
// rccm_div
// restoring divider, one quotient bit per step, for charge time * 1000 / r
// ----------------------------------------------------------------------------
module rccm_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            step,
    input  logic [rccm_pkg::NUM_W-1:0]      num,
    input  logic [rccm_pkg::RES_W-1:0]      den,
    output logic [rccm_pkg::NUM_W-1:0]      quo,
    output logic                            last
);

    localparam int CNT_W = $clog2(rccm_pkg::NUM_W);

    logic [rccm_pkg::NUM_W-1:0] q_reg;
    logic [rccm_pkg::NUM_W-1:0] q_next;
    logic [rccm_pkg::RES_W-1:0] rem_reg;
    logic [rccm_pkg::RES_W-1:0] rem_next;
    logic [rccm_pkg::RES_W-1:0] den_reg;
    logic [rccm_pkg::RES_W-1:0] den_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [rccm_pkg::RES_W:0]   trial;
    logic                       ge;

    always_comb
    begin
        trial    = {rem_reg, q_reg[rccm_pkg::NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            q_next   = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(rccm_pkg::NUM_W - 1);
        end
        else if (step)
        begin
            q_next   = {q_reg[rccm_pkg::NUM_W-2:0], ge};
            rem_next = ge ? rccm_pkg::RES_W'(trial - {1'b0, den_reg})
                          : trial[rccm_pkg::RES_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = q_reg;
    assign last = (cnt_reg == '0);

endmodule

// ===== hw/rtl/rccm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rccm_ctrl
// sequencer: poll execution, capacitance divide and result transfer
// ----------------------------------------------------------------------------
module rccm_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rccm_pkg::dp_cmd_t       cmd,
    input  rccm_pkg::dp_status_t    status
);

    rccm_pkg::ctrl_state_t state_reg;
    rccm_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rccm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            rccm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = rccm_pkg::ST_CHECK;
                end
            end
            rccm_pkg::ST_CHECK:
            begin
                state_next = status.done ? rccm_pkg::ST_DIV_LOAD : rccm_pkg::ST_OUT;
            end
            rccm_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = rccm_pkg::ST_DIV;
            end
            rccm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = rccm_pkg::ST_FINISH;
                end
            end
            rccm_pkg::ST_FINISH:
            begin
                cmd.div_finish = 1'b1;
                state_next     = rccm_pkg::ST_OUT;
            end
            rccm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = rccm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rccm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rccm_dp.sv =====
// ----------------------------------------------------------------------------
// rccm_dp
// datapath: configuration, mode and charge state, autorange and result regs
// ----------------------------------------------------------------------------
module rccm_dp
#(
    parameter int MAX_RANGES = rccm_pkg::MAX_RANGES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rccm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rccm_pkg::RES_W-1:0]          cfg_data,
    input  logic [rccm_pkg::IN_W-1:0]           in_data,
    output logic [rccm_pkg::OUT_W-1:0]          out_data,
    input  rccm_pkg::dp_cmd_t                   cmd,
    output rccm_pkg::dp_status_t                status
);

    localparam int NR = 4;

    // config
    logic [rccm_pkg::RES_W-1:0]     r_ohm_reg [NR];
    logic [2:0]                     range_count_reg;
    logic [2:0]                     pin_count_reg;
    logic [rccm_pkg::SAMPLE_W-1:0]  dis_level_reg;
    logic [rccm_pkg::SAMPLE_W-1:0]  safe_level_reg;

    // poll state
    rccm_pkg::mode_t                mode_reg, mode_next;
    logic                           charging_reg, charging_next;
    logic [1:0]                     range_reg, range_next;
    logic [2:0]                     retry_reg, retry_next;
    logic [rccm_pkg::TIME_W-1:0]    start_reg, start_next;
    logic [3:0]                     mask_reg, mask_next;
    logic                           dis_on_reg, dis_on_next;
    logic [rccm_pkg::TIME_W-1:0]    cap_reg, cap_next;
    logic [rccm_pkg::TIME_W-1:0]    time_reg, time_next;
    logic [rccm_pkg::SAMPLE_W-1:0]  peak_reg, peak_next;
    logic                           done_reg, done_next;
    logic [rccm_pkg::TIME_W-1:0]    dt_reg, dt_next;
    logic [rccm_pkg::NUM_W-1:0]     num_reg;
    logic [rccm_pkg::THR_W-1:0]     thr_reg;

    logic                           in_running;
    logic [rccm_pkg::SAMPLE_W-1:0]  in_sample;
    logic [rccm_pkg::TIME_W-1:0]    in_time;
    logic [rccm_pkg::SAMPLE_W-1:0]  in_rebound;

    logic [2:0]                     np;
    logic                           multi;
    logic                           up_ok;
    logic [rccm_pkg::TIME_W-1:0]    start_v;
    logic [rccm_pkg::TIME_W-1:0]    dt_v;
    logic [rccm_pkg::RES_W-1:0]     r_raw;
    logic [rccm_pkg::RES_W-1:0]     r_sel;
    logic [rccm_pkg::NUM_W-1:0]     num_prod;
    logic [rccm_pkg::NUM_W-1:0]     quo;
    logic                           div_last;

    function automatic logic [3:0] all_pins(input logic [2:0] n);
        logic [3:0] m;
        case (n)
            3'd0:    m = 4'b0000;
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0011;
            3'd3:    m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

    assign in_running = in_data[0];
    assign in_sample  = in_data[10:1];
    assign in_time    = in_data[42:11];
    assign in_rebound = in_data[52:43];

    assign np    = (pin_count_reg > 3'd4) ? 3'd4 : pin_count_reg;
    assign multi = range_count_reg > 3'd1;
    assign up_ok = (({1'b0, range_reg} + 3'd1) < np) && ((int'(range_reg) + 1) < MAX_RANGES);

    always_comb
    begin
        mode_next     = mode_reg;
        charging_next = charging_reg;
        range_next    = range_reg;
        retry_next    = retry_reg;
        start_next    = start_reg;
        mask_next     = mask_reg;
        dis_on_next   = dis_on_reg;
        time_next     = time_reg;
        peak_next     = peak_reg;
        done_next     = done_reg;
        dt_next       = dt_reg;
        start_v       = start_reg;
        dt_v          = '0;
        if (cmd.exec)
        begin
            done_next = 1'b0;
            case (mode_reg)
                rccm_pkg::MODE_CHG:
                begin
                    if (!charging_reg)
                    begin
                        if (multi)
                        begin
                            mask_next = ({1'b0, range_reg} < np) ? (4'b0001 << range_reg)
                                                                  : 4'b0000;
                        end
                        else
                        begin
                            mask_next = all_pins(np);
                        end
                        start_v       = in_time;
                        charging_next = 1'b1;
                    end
                    start_next = start_v;
                    dt_v       = in_time - start_v;
                    if (in_sample < rccm_pkg::CHARGE_LEVEL)
                    begin
                        // too slow: step down a range
                        if (dt_v > rccm_pkg::LONG_US && range_reg != 2'd0 && multi)
                        begin
                            charging_next = 1'b0;
                            mode_next     = rccm_pkg::MODE_DIS;
                            mask_next     = '0;
                            dis_on_next   = 1'b0;
                            range_next    = range_reg - 2'd1;
                            retry_next    = (retry_reg < 3'd7) ? retry_reg + 3'd1 : retry_reg;
                        end
                    end
                    else if (dt_v < rccm_pkg::SHORT_US && multi && retry_reg < 3'd2 && up_ok)
                    begin
                        // too fast: step up a range
                        range_next    = range_reg + 2'd1;
                        retry_next    = (retry_reg < 3'd7) ? retry_reg + 3'd1 : retry_reg;
                        charging_next = 1'b0;
                        mode_next     = rccm_pkg::MODE_DIS;
                        mask_next     = '0;
                        dis_on_next   = 1'b0;
                    end
                    else
                    begin
                        charging_next = 1'b0;
                        mode_next     = rccm_pkg::MODE_DIS;
                        mask_next     = '0;
                        dis_on_next   = 1'b0;
                        time_next     = dt_v;
                        peak_next     = in_sample;
                        retry_next    = '0;
                        done_next     = 1'b1;
                        dt_next       = dt_v;
                    end
                    if (!in_running)
                    begin
                        charging_next = 1'b0;
                        mode_next     = rccm_pkg::MODE_DIS;
                        mask_next     = '0;
                        dis_on_next   = 1'b0;
                    end
                end
                rccm_pkg::MODE_SAFE:
                begin
                    if (in_running)
                    begin
                        mode_next = rccm_pkg::MODE_CHG;
                    end
                    else if (in_sample > safe_level_reg)
                    begin
                        mode_next = rccm_pkg::MODE_DIS;
                    end
                end
                default:
                begin
                    mode_next = rccm_pkg::MODE_DIS;
                    if (in_sample > dis_level_reg)
                    begin
                        dis_on_next = 1'b1;
                    end
                    else if (in_rebound <= dis_level_reg)
                    begin
                        charging_next = 1'b0;
                        mask_next     = '0;
                        dis_on_next   = 1'b0;
                        mode_next     = rccm_pkg::MODE_SAFE;
                    end
                end
            endcase
        end
    end

    // capacitance: resistor select, scaling and saturation
    assign r_raw    = multi ? r_ohm_reg[range_reg] : r_ohm_reg[0];
    assign r_sel    = (r_raw == '0) ? rccm_pkg::RES_W'(1) : r_raw;
    assign num_prod = rccm_pkg::NUM_W'(dt_reg) * rccm_pkg::NUM_W'(rccm_pkg::NF_SCALE);

    always_comb
    begin
        cap_next = cap_reg;
        if (cmd.div_finish)
        begin
            if (num_reg <= rccm_pkg::NUM_W'(thr_reg))
            begin
                cap_next = '0;
            end
            else if (quo[rccm_pkg::NUM_W-1:rccm_pkg::TIME_W] != '0)
            begin
                cap_next = '1;
            end
            else
            begin
                cap_next = quo[rccm_pkg::TIME_W-1:0];
            end
        end
    end

    rccm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.div_load),
        .step  (cmd.div_step),
        .num   (num_prod),
        .den   (r_sel),
        .quo   (quo),
        .last  (div_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_ohm_reg[0]    <= 24'd1000;
            r_ohm_reg[1]    <= 24'd10000;
            r_ohm_reg[2]    <= 24'd100000;
            r_ohm_reg[3]    <= 24'd1000000;
            range_count_reg <= 3'd1;
            pin_count_reg   <= 3'd1;
            dis_level_reg   <= 10'd10;
            safe_level_reg  <= 10'd20;
            mode_reg        <= rccm_pkg::MODE_DIS;
            charging_reg    <= 1'b0;
            range_reg       <= '0;
            retry_reg       <= '0;
            start_reg       <= '0;
            mask_reg        <= '0;
            dis_on_reg      <= 1'b0;
            cap_reg         <= '0;
            time_reg        <= '0;
            peak_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rccm_pkg::REG_R_OHM_0:     r_ohm_reg[0]    <= cfg_data;
                    rccm_pkg::REG_R_OHM_1:     r_ohm_reg[1]    <= cfg_data;
                    rccm_pkg::REG_R_OHM_2:     r_ohm_reg[2]    <= cfg_data;
                    rccm_pkg::REG_R_OHM_3:     r_ohm_reg[3]    <= cfg_data;
                    rccm_pkg::REG_RANGE_COUNT: range_count_reg <= cfg_data[2:0];
                    rccm_pkg::REG_PIN_COUNT:   pin_count_reg   <= cfg_data[2:0];
                    rccm_pkg::REG_DIS_LEVEL:   dis_level_reg   <= cfg_data[9:0];
                    rccm_pkg::REG_SAFE_LEVEL:  safe_level_reg  <= cfg_data[9:0];
                    default:                   ;
                endcase
            end
            mode_reg     <= mode_next;
            charging_reg <= charging_next;
            range_reg    <= range_next;
            retry_reg    <= retry_next;
            start_reg    <= start_next;
            mask_reg     <= mask_next;
            dis_on_reg   <= dis_on_next;
            cap_reg      <= cap_next;
            time_reg     <= time_next;
            peak_reg     <= peak_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg <= dt_next;
        if (cmd.div_load)
        begin
            num_reg <= num_prod;
            thr_reg <= rccm_pkg::THR_W'(r_sel) * rccm_pkg::THR_W'(rccm_pkg::MIN_NF);
        end
    end

    assign status.done     = done_reg;
    assign status.div_last = div_last;

    assign out_data = {4'b0000, range_reg, peak_reg, time_reg, cap_reg,
                       done_reg, dis_on_reg, mask_reg, mode_reg};

endmodule

// ===== hw/rtl/rc_capacitance_meter_autorange_top.sv =====
// ----------------------------------------------------------------------------
// rc_capacitance_meter_autorange_top
// rc time-constant capacitance meter with resistor autoranging
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     content
//  s_axis    in         s_axis_tvalid/s_axis_tready   one adc poll
//  m_axis    out        m_axis_tvalid/m_axis_tready   one status/result per poll
//  cfg       in         cfg_we                        register write, no read-back
//
//  a poll with no finished measurement goes from ST_CHECK straight to ST_OUT
//  a completed measurement adds ST_DIV_LOAD, 42-step restoring divider, ST_FINISH
//  one poll is in flight at a time; input is not taken until the result transfers
//  a stalled result holds its value while m_axis_tready is low
//  after reset the block is in discharging mode with default registers
// ----------------------------------------------------------------------------
module rc_capacitance_meter_autorange_top
#(
    parameter int MAX_RANGES = rccm_pkg::MAX_RANGES_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // running, sample[10], time_us[32], rebound_sample[10]
    input  logic [rccm_pkg::IN_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mode[2], charge_drive[4], discharge_drive, new_result, capacitance_nf[32],
    // charge_time_us[32], peak_sample[10], range_index[2]
    output logic [rccm_pkg::OUT_W-1:0]          m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [rccm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rccm_pkg::RES_W-1:0]          cfg_data
);

    rccm_pkg::dp_cmd_t    cmd;
    rccm_pkg::dp_status_t status;

    rccm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    rccm_dp
    #(
        .MAX_RANGES (MAX_RANGES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
